@@ rtl/puc_pkg.sv @@
// Shared types, constants and character helpers for the percent URL codec.
// No dependencies; imported by every module of the codec.
`default_nettype none

package puc_pkg;

   localparam int POS_W     = 16;  // position counter; error offset is the same width
   localparam int OFF_W     = 16;
   localparam int QDEPTH    = 4;
   localparam int QPTR_W    = $clog2(QDEPTH);
   localparam int QCNT_W    = QPTR_W + 1;

   localparam logic [1:0] ERR_RESERVED  = 2'd0;
   localparam logic [1:0] ERR_NON_ASCII = 2'd1;
   localparam logic [1:0] ERR_BAD_HEX   = 2'd2;
   localparam logic [1:0] ERR_TRUNCATED = 2'd3;

   localparam logic [1:0] PH_IDLE = 2'd0;
   localparam logic [1:0] PH_HIGH = 2'd1;
   localparam logic [1:0] PH_LOW  = 2'd2;

   localparam logic REG_DIRECTION = 1'b0;
   localparam logic REG_USE_PLUS  = 1'b1;

   localparam logic [7:0] CH_SPACE   = 8'h20;
   localparam logic [7:0] CH_PLUS    = 8'h2B;
   localparam logic [7:0] CH_PERCENT = 8'h25;

   typedef struct packed {
      logic direction;
      logic use_plus;
   } cfg_type;

   // One queued job: a single byte, a three-beat escape or an error report.
   typedef struct packed {
      logic             esc;
      logic [7:0]       data;
      logic             is_error;
      logic [1:0]       kind;
      logic [OFF_W-1:0] offset;
   } job_type;

   function automatic logic is_reserved(input logic [7:0] c);
      logic r;
      case (c)
         8'h3A, 8'h2F, 8'h3F, 8'h23, 8'h5B, 8'h5D, 8'h40, 8'h21, 8'h24, 8'h26,
         8'h27, 8'h28, 8'h29, 8'h2A, 8'h2B, 8'h2C, 8'h3B, 8'h3D, 8'h25: r = 1'b1;
         default: r = 1'b0;
      endcase
      return r;
   endfunction

   // {valid, value}
   function automatic logic [4:0] hex_value(input logic [7:0] c);
      logic [4:0] r;
      if (c >= 8'h30 && c <= 8'h39)      r = {1'b1, c[3:0]};
      else if (c >= 8'h41 && c <= 8'h46) r = {1'b1, 4'(c[3:0] + 4'd9)};
      else if (c >= 8'h61 && c <= 8'h66) r = {1'b1, 4'(c[3:0] + 4'd9)};
      else                               r = 5'd0;
      return r;
   endfunction

   function automatic logic [7:0] hex_digit(input logic [3:0] v);
      logic [7:0] r;
      if (v < 4'd10) r = 8'h30 + {4'd0, v};
      else           r = 8'h37 + {4'd0, v};
      return r;
   endfunction

endpackage

`default_nettype wire

@@ rtl/puc_front.sv @@
// Front end: takes input beats, tracks escape and position state, classifies
// each character into a queued job. Depends on puc_pkg.
`default_nettype none

module puc_front
   import puc_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       accept,
   input  wire logic [7:0] in_char,
   input  wire logic       last_in,
   input  wire cfg_type    cfg,
   output logic            push,
   output job_type         job
);

   logic [1:0]       phase_ff, phase_in;
   logic [3:0]       high_ff, high_in;
   logic [POS_W-1:0] pos_ff, pos_in;
   logic             halted_ff, halted_in;
   logic [4:0]       hv;
   logic             gen;

   always_comb begin
      phase_in  = phase_ff;
      high_in   = high_ff;
      pos_in    = pos_ff;
      halted_in = halted_ff;
      gen       = 1'b0;
      job       = '0;
      hv        = hex_value(in_char);

      if (!halted_ff) begin
         if (!cfg.direction) begin
            gen = 1'b1;
            if (in_char == CH_SPACE && cfg.use_plus) begin
               job.data = CH_PLUS;
            end else if (in_char == CH_SPACE || is_reserved(in_char) || in_char[7]) begin
               job.esc  = 1'b1;
               job.data = in_char;
            end else begin
               job.data = in_char;
            end
         end else begin
            case (phase_ff)
               PH_HIGH: begin
                  gen = 1'b1;
                  if (last_in) begin
                     job.is_error = 1'b1;
                     job.kind     = ERR_TRUNCATED;
                  end else if (!hv[4]) begin
                     job.is_error = 1'b1;
                     job.kind     = ERR_BAD_HEX;
                  end else begin
                     gen      = 1'b0;
                     high_in  = hv[3:0];
                     phase_in = PH_LOW;
                  end
               end
               PH_LOW: begin
                  gen = 1'b1;
                  if (!hv[4]) begin
                     job.is_error = 1'b1;
                     job.kind     = ERR_BAD_HEX;
                  end else begin
                     phase_in = PH_IDLE;
                     job.data = {high_ff, hv[3:0]};
                  end
               end
               default: begin
                  gen = 1'b1;
                  if (in_char == CH_PLUS) begin
                     job.data = CH_SPACE;
                  end else if (in_char == CH_PERCENT) begin
                     if (last_in) begin
                        job.is_error = 1'b1;
                        job.kind     = ERR_TRUNCATED;
                     end else begin
                        gen      = 1'b0;
                        phase_in = PH_HIGH;
                     end
                  end else if (in_char == CH_SPACE || is_reserved(in_char)) begin
                     job.is_error = 1'b1;
                     job.kind     = ERR_RESERVED;
                  end else if (in_char[7]) begin
                     job.is_error = 1'b1;
                     job.kind     = ERR_NON_ASCII;
                  end else begin
                     job.data = in_char;
                  end
               end
            endcase
         end
      end

      if (job.is_error) begin
         job.offset = pos_ff;
         halted_in  = 1'b1;
      end

      if (last_in) begin
         phase_in  = PH_IDLE;
         high_in   = '0;
         pos_in    = '0;
         halted_in = 1'b0;
      end else if (pos_ff != '1) begin
         pos_in = pos_ff + 1'b1;
      end

      push = accept && gen;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= PH_IDLE;
         high_ff   <= '0;
         pos_ff    <= '0;
         halted_ff <= 1'b0;
      end else if (accept) begin
         phase_ff  <= phase_in;
         high_ff   <= high_in;
         pos_ff    <= pos_in;
         halted_ff <= halted_in;
      end
   end

endmodule

`default_nettype wire

@@ rtl/puc_queue.sv @@
// Short job queue between front and back ends, flip-flop storage, head read
// straight from the entry at the read pointer. Depends on puc_pkg.
`default_nettype none

module puc_queue
   import puc_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    push,
   input  wire job_type push_job,
   input  wire logic    pop,
   output logic         full,
   output logic         head_valid,
   output job_type      head_job
);

   job_type           entry_ff [QDEPTH];
   logic [QPTR_W-1:0] wr_ff, rd_ff;
   logic [QCNT_W-1:0] cnt_ff, cnt_in;

   assign full       = (cnt_ff == QCNT_W'(QDEPTH));
   assign head_valid = (cnt_ff != '0);
   assign head_job   = entry_ff[rd_ff];

   always_comb begin
      cnt_in = cnt_ff;
      if (push && !pop)      cnt_in = cnt_ff + 1'b1;
      else if (!push && pop) cnt_in = cnt_ff - 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
         if (push) wr_ff <= wr_ff + 1'b1;
         if (pop)  rd_ff <= rd_ff + 1'b1;
      end
      if (push) entry_ff[wr_ff] <= push_job;
   end

endmodule

`default_nettype wire

@@ rtl/puc_back.sv @@
// Back end: expands the head job into one or three result beats and holds
// them in the output register. Depends on puc_pkg.
`default_nettype none

module puc_back
   import puc_pkg::*;
(
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             head_valid,
   input  wire job_type          head_job,
   output logic                  pop,
   output logic                  rsp_tvalid,
   input  wire logic             rsp_tready,
   output logic [7:0]            out_char,
   output logic                  is_error,
   output logic [1:0]            error_kind,
   output logic [OFF_W-1:0]      error_offset,
   output logic                  last_out
);

   logic             valid_ff, valid_in;
   logic [1:0]       beat_ff, beat_in;
   logic [7:0]       char_ff, char_in;
   logic             err_ff;
   logic [1:0]       kind_ff;
   logic [OFF_W-1:0] off_ff;
   logic             last_ff, last_in;
   logic             load;

   always_comb begin
      load     = !valid_ff || rsp_tready;
      valid_in = valid_ff && !rsp_tready;
      beat_in  = beat_ff;
      pop      = 1'b0;
      last_in  = 1'b0;
      char_in  = head_job.data;
      if (head_job.esc) begin
         case (beat_ff)
            2'd0:    char_in = CH_PERCENT;
            2'd1:    char_in = hex_digit(head_job.data[7:4]);
            default: char_in = hex_digit(head_job.data[3:0]);
         endcase
         last_in = (beat_ff == 2'd2);
      end else begin
         last_in = 1'b1;
      end
      if (load && head_valid) begin
         valid_in = 1'b1;
         if (last_in) begin
            pop     = 1'b1;
            beat_in = '0;
         end else begin
            beat_in = beat_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         beat_ff  <= '0;
      end else begin
         valid_ff <= valid_in;
         beat_ff  <= beat_in;
      end
      if (load && head_valid) begin
         char_ff <= char_in;
         err_ff  <= head_job.is_error;
         kind_ff <= head_job.kind;
         off_ff  <= head_job.offset;
         last_ff <= last_in;
      end
   end

   assign rsp_tvalid   = valid_ff;
   assign out_char     = char_ff;
   assign is_error     = err_ff;
   assign error_kind   = kind_ff;
   assign error_offset = off_ff;
   assign last_out     = last_ff;

endmodule

`default_nettype wire

@@ rtl/percent_url_codec.sv @@
// Top level of the streaming percent URL codec: register port, front end,
// job queue and back end. Depends on puc_pkg, puc_front, puc_queue, puc_back.
//
//   port group | role           | beat contents
//   req_*      | input stream   | tdata: in_char; tlast: last_in
//   rsp_*      | result stream  | tdata: out_char, error_offset; tuser: is_error,
//              |                |   error_kind; tlast: last_out
//   csr_*      | register port  | 0x0 direction, 0x4 use_plus
//
// One input beat per cycle while the queue has room; an encoded escape takes
// three result beats, so the input stalls on runs of escapes once the
// four-entry queue fills. Results leave the output register one beat per
// cycle while rsp_tready is high. Synchronous reset clears state and queue;
// no clearing pass. Either side may stall freely.
`default_nettype none

module percent_url_codec
   import puc_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [7:0]  req_tdata,   // [7:0] in_char
   input  wire logic        req_tlast,
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [23:0]      rsp_tdata,   // [7:0] out_char, [23:8] error_offset
   output logic [2:0]       rsp_tuser,   // [0] is_error, [2:1] error_kind
   output logic             rsp_tlast,
   input  wire logic        csr_psel,
   input  wire logic        csr_penable,
   input  wire logic        csr_pwrite,
   input  wire logic [2:0]  csr_paddr,
   input  wire logic [31:0] csr_pwdata,
   output logic [31:0]      csr_prdata,
   output logic             csr_pready
);

   logic             direction_ff, use_plus_ff;
   cfg_type          cfg;
   logic             accept, push, pop, full, head_valid;
   job_type          job, head_job;
   logic [7:0]       out_char;
   logic             is_error, last_out;
   logic [1:0]       error_kind;
   logic [OFF_W-1:0] error_offset;
   logic             wr_en;

   assign csr_pready = 1'b1;
   assign wr_en      = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         direction_ff <= 1'b0;
         use_plus_ff  <= 1'b1;
      end else if (wr_en) begin
         unique case (csr_paddr[2])
            REG_DIRECTION: direction_ff <= csr_pwdata[0];
            REG_USE_PLUS:  use_plus_ff  <= csr_pwdata[0];
            default:       ;
         endcase
      end
   end

   always_comb begin
      unique case (csr_paddr[2])
         REG_DIRECTION: csr_prdata = {31'd0, direction_ff};
         REG_USE_PLUS:  csr_prdata = {31'd0, use_plus_ff};
         default:       csr_prdata = '0;
      endcase
   end

   assign cfg.direction = direction_ff;
   assign cfg.use_plus  = use_plus_ff;

   assign req_tready = !full;
   assign accept     = req_tvalid && req_tready;

   puc_front u_front (
      .clock   (clock),
      .reset   (reset),
      .accept  (accept),
      .in_char (req_tdata),
      .last_in (req_tlast),
      .cfg     (cfg),
      .push    (push),
      .job     (job)
   );

   puc_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_job   (job),
      .pop        (pop),
      .full       (full),
      .head_valid (head_valid),
      .head_job   (head_job)
   );

   puc_back u_back (
      .clock        (clock),
      .reset        (reset),
      .head_valid   (head_valid),
      .head_job     (head_job),
      .pop          (pop),
      .rsp_tvalid   (rsp_tvalid),
      .rsp_tready   (rsp_tready),
      .out_char     (out_char),
      .is_error     (is_error),
      .error_kind   (error_kind),
      .error_offset (error_offset),
      .last_out     (last_out)
   );

   assign rsp_tdata = {error_offset, out_char};
   assign rsp_tuser = {error_kind, is_error};
   assign rsp_tlast = last_out;

endmodule

`default_nettype wire
